### rtl/w2e_pkg.sv
// shared types and constants for the 802.11 to ethernet header translator
// used by every module in rtl; no dependencies
package w2e_pkg;

  // register map, byte address 4*i
  localparam int RegAddrWidth = 3;
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_MTU = 1'b1;

  localparam logic [11:0] MTU_RESET = 12'd1500;

  // payload classes
  localparam logic [1:0] CLS_RAW = 2'd0;
  localparam logic [1:0] CLS_SNAP = 2'd1;
  localparam logic [1:0] CLS_DIX = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  localparam logic [7:0] LLC_SAP = 8'hAA;
  localparam logic [7:0] LLC_UI = 8'h03;
  localparam logic [23:0] OUI_RFC1042 = 24'h000000;
  localparam logic [15:0] AARP_TYPE = 16'h80F3;

  localparam logic [11:0] HDR_CRC_BYTES = 12'd28;
  localparam logic [11:0] ADDR4_BYTES = 12'd6;
  localparam logic [5:0] HDR3_BYTES = 6'd24;
  localparam logic [5:0] HDR4_BYTES = 6'd30;
  localparam logic [5:0] SNAP_BYTES = 6'd8;
  localparam logic [12:0] ETH_HDR_BYTES = 13'd14;

  typedef struct packed {
    logic [15:0] frame_control;
    logic [47:0] address_one;
    logic [47:0] address_two;
    logic [47:0] address_three;
    logic [47:0] address_four;
    logic [11:0] frame_length;
    logic [47:0] payload_bytes_low;
    logic [47:0] payload_bytes_high;
  } in_item_t;

  typedef struct packed {
    logic        verdict;
    logic [1:0]  frame_class;
    logic [47:0] ether_destination;
    logic [47:0] ether_source;
    logic [15:0] ether_type_or_length;
    logic        add_ether_header;
    logic [5:0]  strip_front_bytes;
    logic [11:0] payload_length;
  } out_item_t;

  typedef struct packed {
    logic        selective_translation_mode;
    logic [11:0] max_transfer_unit;
  } cfg_t;

endpackage

### rtl/w2e_cfg_regs.sv
// apb register block: translation mode and mtu
// depends on w2e_pkg
module w2e_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [w2e_pkg::RegAddrWidth-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output w2e_pkg::cfg_t                    cfg
);
  import w2e_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.selective_translation_mode <= 1'b0;
      cfg.max_transfer_unit <= MTU_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MODE: cfg.selective_translation_mode <= pwdata[0];
        REG_MTU:  cfg.max_transfer_unit <= pwdata[11:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODE: prdata = {31'd0, cfg.selective_translation_mode};
      REG_MTU:  prdata = {20'd0, cfg.max_transfer_unit};
      default:  prdata = 32'd0;
    endcase
  end

endmodule

### rtl/w2e_xlate.sv
// header translation datapath: length, address selection, classification
// purely combinational; depends on w2e_pkg
module w2e_xlate (
  input  w2e_pkg::in_item_t  item,
  input  w2e_pkg::cfg_t      cfg,
  output w2e_pkg::out_item_t result
);
  import w2e_pkg::*;

  logic        to_ds;
  logic        from_ds;
  logic        too_short;
  logic        four_short;
  logic [11:0] plen0;
  logic [11:0] plen;
  logic [5:0]  offset;
  logic [47:0] dst;
  logic [47:0] src;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [23:0] oui;
  logic [15:0] snap_type;
  logic        llc_snap;
  logic        is_raw;
  logic        is_kept;
  logic [12:0] raw_limit;
  logic [11:0] dix_len;
  logic        oversize;
  logic [1:0]  cls;

  assign to_ds = item.frame_control[8];
  assign from_ds = item.frame_control[9];
  assign too_short = item.frame_length < HDR_CRC_BYTES;
  assign plen0 = item.frame_length - HDR_CRC_BYTES;
  assign four_short = to_ds && from_ds && (plen0 < ADDR4_BYTES);
  assign plen = (to_ds && from_ds) ? plen0 - ADDR4_BYTES : plen0;
  assign offset = (to_ds && from_ds) ? HDR4_BYTES : HDR3_BYTES;

  always_comb begin
    case ({to_ds, from_ds})
      2'b00: begin
        dst = item.address_one;
        src = item.address_two;
      end
      2'b01: begin
        dst = item.address_one;
        src = item.address_three;
      end
      2'b10: begin
        dst = item.address_three;
        src = item.address_two;
      end
      default: begin
        dst = item.address_three;
        src = item.address_four;
      end
    endcase
  end

  assign b0 = item.payload_bytes_low[47:40];
  assign b1 = item.payload_bytes_low[39:32];
  assign b2 = item.payload_bytes_low[31:24];
  assign oui = item.payload_bytes_low[23:0];
  assign snap_type = item.payload_bytes_high[47:32];

  assign llc_snap = (plen >= 12'd8) && (b0 == LLC_SAP) && (b1 == LLC_SAP) && (b2 == LLC_UI);
  // raw 802.3 frames: no double llc sap, and the payload start differs from the selected addresses
  assign is_raw = (plen >= 12'd14) && !((b0 == LLC_SAP) && (b1 == LLC_SAP)) &&
                  ((dst != item.payload_bytes_low) || (src != item.payload_bytes_high));
  assign is_kept = llc_snap && ((oui != OUI_RFC1042) ||
                   (cfg.selective_translation_mode && (snap_type == AARP_TYPE)));

  assign raw_limit = {1'b0, cfg.max_transfer_unit} + ETH_HDR_BYTES;
  assign dix_len = plen - 12'(SNAP_BYTES);

  always_comb begin
    if (is_raw) begin
      cls = CLS_RAW;
      oversize = {1'b0, plen} > raw_limit;
    end else if (is_kept) begin
      cls = CLS_SNAP;
      oversize = plen > cfg.max_transfer_unit;
    end else if (llc_snap) begin
      cls = CLS_DIX;
      oversize = dix_len > cfg.max_transfer_unit;
    end else begin
      cls = CLS_OTHER;
      oversize = plen > cfg.max_transfer_unit;
    end
  end

  always_comb begin
    result = '0;
    if (too_short || four_short || oversize) begin
      result.verdict = 1'b1;
    end else begin
      result.frame_class = cls;
      result.ether_destination = dst;
      result.ether_source = src;
      result.payload_length = plen;
      result.strip_front_bytes = offset;
      case (cls)
        CLS_RAW: begin
          result.ether_type_or_length = 16'd0;
          result.add_ether_header = 1'b0;
        end
        CLS_DIX: begin
          result.ether_type_or_length = snap_type;
          result.add_ether_header = 1'b1;
          result.strip_front_bytes = offset + SNAP_BYTES;
        end
        default: begin
          result.ether_type_or_length = {4'd0, plen};
          result.add_ether_header = 1'b1;
        end
      endcase
    end
  end

endmodule

### rtl/wifi_to_ethernet_header_translator_unit.sv
// top level of the 802.11 to ethernet receive header translator
// depends on w2e_pkg, w2e_cfg_regs, w2e_xlate
//
// usage:
//   input channel (in_valid/in_ready/in_data) takes one 802.11 data frame
//   header summary per transaction; output channel (out_valid/out_ready/
//   out_data) returns one translation result per input transaction, in order.
//   the apb port sets the translation mode (0x0) and the mtu (0x4); write it
//   only while no transaction is in flight.
// pipeline:
//   input acceptance loads the input register; the translation logic then
//   feeds the result register. one transaction per cycle sustained while
//   out_ready is high; both registers advance together whenever the result
//   register is empty or being taken.
// reset:
//   synchronous rst empties both registers, mode returns to 0, mtu to 1500.
// stalls:
//   with out_ready low the result holds, the input register fills, and
//   in_ready drops only once both registers are occupied.
module wifi_to_ethernet_header_translator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  w2e_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output w2e_pkg::out_item_t               out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [w2e_pkg::RegAddrWidth-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import w2e_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  logic      item_valid;
  out_item_t result_next;
  logic      advance;

  w2e_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  w2e_xlate u_xlate (
    .item   (item),
    .cfg    (cfg),
    .result (result_next)
  );

  // result register free this cycle
  assign advance = !out_valid || out_ready;
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (advance && item_valid) begin
      out_data <= result_next;
    end
  end

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict |->
      out_data.payload_length == 12'd0 && !out_data.add_ether_header &&
      out_data.strip_front_bytes == 6'd0)
    else $error("rejected result carries nonzero fields");

  a_dix_strip: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.verdict && out_data.frame_class == CLS_DIX |->
      out_data.strip_front_bytes == 6'd32 || out_data.strip_front_bytes == 6'd38)
    else $error("dix result with wrong strip count");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    item_valid && out_valid && !out_ready |=> item_valid && out_valid)
    else $error("pending transaction lost during stall");

  a_mtu_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] == REG_MTU |=>
      cfg.max_transfer_unit == $past(pwdata[11:0]))
    else $error("mtu register write not taken");

endmodule

### sim/tb_top.sv
// testbench for the 802.11 to ethernet receive header translator
// drives frame header summaries and apb register writes, checks every translation
// depends on rtl/w2e_pkg.sv and rtl/wifi_to_ethernet_header_translator_unit.sv
`timescale 1ns / 1ps

module tb_top;
  import w2e_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;
  localparam int TO_DS_BIT = 8;
  localparam int FROM_DS_BIT = 9;

  localparam logic [RegAddrWidth-1:0] ADDR_MODE = {REG_MODE, 2'b00};
  localparam logic [RegAddrWidth-1:0] ADDR_MTU = {REG_MTU, 2'b00};

  // data frame subtype with the four distribution-system combinations
  localparam logic [15:0] FC_NO_DS = 16'h0008;
  localparam logic [15:0] FC_TO_DS = 16'h0108;
  localparam logic [15:0] FC_FROM_DS = 16'h0208;
  localparam logic [15:0] FC_WDS = 16'h0308;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPX = 16'h8137;
  localparam logic [47:0] PL_RFC1042 = {LLC_SAP, LLC_SAP, LLC_UI, OUI_RFC1042};
  localparam logic [47:0] PL_VENDOR_SNAP = {LLC_SAP, LLC_SAP, LLC_UI, 24'h0000F8};
  localparam logic [47:0] PL_RAW = 48'h0800_4500_0054;
  localparam logic [47:0] PL_BAD_CTRL = {LLC_SAP, LLC_SAP, 8'h04, 24'h000000};
  localparam logic [47:0] PL_HALF_SAP = {LLC_SAP, 8'h00, LLC_UI, 24'h000000};
  localparam logic [47:0] PL_JUNK_SAP = {LLC_SAP, LLC_SAP, 8'h7E, 24'h123456};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [RegAddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // register mirrors, reset values
  logic cfg_mode = 1'b0;
  logic [11:0] cfg_mtu = MTU_RESET;

  out_item_t expected_translations[$];
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int settings_used = 1;
  int rejected_count = 0;
  int class_count[4] = '{0, 0, 0, 0};

  wifi_to_ethernet_header_translator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // expected ethernet translation of one frame header under the current registers
  function automatic out_item_t translate_frame(in_item_t f);
    out_item_t r;
    logic to_ds, from_ds, llc;
    int plen, mtu;
    logic [5:0] strip;
    logic [47:0] dst, src;
    logic [7:0] b0, b1, b2;
    logic [23:0] oui;
    logic [15:0] snap_type;
    r = '0;
    r.verdict = 1'b1;
    to_ds = f.frame_control[TO_DS_BIT];
    from_ds = f.frame_control[FROM_DS_BIT];
    mtu = int'(cfg_mtu);
    if (f.frame_length < HDR_CRC_BYTES) return r;
    plen = int'(f.frame_length) - int'(HDR_CRC_BYTES);
    strip = HDR3_BYTES;
    dst = to_ds ? f.address_three : f.address_one;
    src = !from_ds ? f.address_two : (to_ds ? f.address_four : f.address_three);
    if (to_ds && from_ds) begin
      if (plen < int'(ADDR4_BYTES)) return r;
      plen = plen - int'(ADDR4_BYTES);
      strip = HDR4_BYTES;
    end
    {b0, b1, b2, oui} = f.payload_bytes_low;
    snap_type = f.payload_bytes_high[47:32];
    llc = plen >= int'(SNAP_BYTES) && b0 == LLC_SAP && b1 == LLC_SAP && b2 == LLC_UI;
    // payload that already carries an ethernet header goes out untouched
    if (plen >= int'(ETH_HDR_BYTES) && !(b0 == LLC_SAP && b1 == LLC_SAP) &&
        (dst != f.payload_bytes_low || src != f.payload_bytes_high)) begin
      if (plen > mtu + int'(ETH_HDR_BYTES)) return r;
      r.frame_class = CLS_RAW;
    end else if (llc && (oui != OUI_RFC1042 || (cfg_mode && snap_type == AARP_TYPE))) begin
      if (plen > mtu) return r;
      r.frame_class = CLS_SNAP;
      r.ether_type_or_length = plen[15:0];
      r.add_ether_header = 1'b1;
    end else if (llc) begin
      if (plen - int'(SNAP_BYTES) > mtu) return r;
      r.frame_class = CLS_DIX;
      r.ether_type_or_length = snap_type;
      r.add_ether_header = 1'b1;
      strip = strip + SNAP_BYTES;
    end else begin
      if (plen > mtu) return r;
      r.frame_class = CLS_OTHER;
      r.ether_type_or_length = plen[15:0];
      r.add_ether_header = 1'b1;
    end
    r.verdict = 1'b0;
    r.ether_destination = dst;
    r.ether_source = src;
    r.strip_front_bytes = strip;
    r.payload_length = plen[11:0];
    return r;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("verdict=%0d class=%0d dst=%h src=%h type_len=%h add=%0d strip=%0d len=%0d",
                     r.verdict, r.frame_class, r.ether_destination, r.ether_source,
                     r.ether_type_or_length, r.add_ether_header, r.strip_front_bytes,
                     r.payload_length);
  endfunction

  function automatic in_item_t frame_of(logic [15:0] fc, int len, logic [47:0] lo,
                                        logic [47:0] hi);
    in_item_t f;
    logic [31:0] l;
    l = len;
    f.frame_control = fc;
    f.address_one = rand48();
    f.address_two = rand48();
    f.address_three = rand48();
    f.address_four = rand48();
    f.frame_length = l[11:0];
    f.payload_bytes_low = lo;
    f.payload_bytes_high = hi;
    return f;
  endfunction

  // mostly well-formed frames of each class, lengths clustered at the mtu edges
  function automatic in_item_t random_frame();
    in_item_t f;
    logic [31:0] w;
    int plen, hdr;
    logic [47:0] dst, src, lo, hi;
    w = $urandom;
    f = frame_of(w[15:0], 0, rand48(), rand48());
    hdr = (w[FROM_DS_BIT] && w[TO_DS_BIT]) ? 34 : 28;
    case ($urandom_range(0, 9))
      0: plen = $urandom_range(0, 16);
      1, 2, 3, 4: plen = int'(cfg_mtu) + $urandom_range(0, 30) - 8;
      default: plen = $urandom_range(0, 4095);
    endcase
    if (plen < 0) plen = 0;
    w = plen + hdr;
    f.frame_length = (w > 32'd4095) ? 12'hFFF : w[11:0];
    if ($urandom_range(0, 19) == 0) begin
      w = $urandom_range(0, 40);
      f.frame_length = w[11:0];
    end
    dst = f.frame_control[TO_DS_BIT] ? f.address_three : f.address_one;
    src = !f.frame_control[FROM_DS_BIT] ? f.address_two :
          (f.frame_control[TO_DS_BIT] ? f.address_four : f.address_three);
    lo = rand48();
    hi = rand48();
    case ($urandom_range(0, 9))
      0, 1: begin
        if (lo[47:32] == {LLC_SAP, LLC_SAP}) lo[40] = ~lo[40];
      end
      2, 3: lo[47:24] = {LLC_SAP, LLC_SAP, LLC_UI};
      4, 5, 6: begin
        lo = PL_RFC1042;
        if ($urandom_range(0, 2) == 0) hi[47:32] = AARP_TYPE;
      end
      7: begin
        lo = dst;
        hi = src;
      end
      8: begin
        lo[47:40] = LLC_SAP;
        if ($urandom_range(0, 1) == 1) lo[39:32] = LLC_SAP;
      end
      default: ;
    endcase
    f.payload_bytes_low = lo;
    f.payload_bytes_high = hi;
    return f;
  endfunction

  task automatic send_frame(in_item_t f);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (!in_ready);
    expected_translations.push_back(translate_frame(f));
    frames_sent++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_translations.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result with nothing outstanding: %s", show(got));
      return;
    end
    want = expected_translations.pop_front();
    results_checked++;
    if (want.verdict) rejected_count++;
    else class_count[want.frame_class]++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("mismatch on result %0d", results_checked);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_result(out_data);
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycles,
             expected_translations.size());
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_translations.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [RegAddrWidth-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits carry junk that the block must drop
  task automatic set_config(logic mode, logic [11:0] mtu);
    logic [31:0] junk;
    wait_drained();
    junk = $urandom;
    write_register(ADDR_MODE, {junk[31:1], mode});
    junk = $urandom;
    write_register(ADDR_MTU, {junk[31:12], mtu});
    cfg_mode = mode;
    cfg_mtu = mtu;
    settings_used++;
  endtask

  task automatic run_random_frames(int count, int idle_pct, int stall_pct);
    send_idle = idle_pct;
    recv_stall = stall_pct;
    repeat (count) send_frame(random_frame());
    wait_drained();
  endtask

  // boundaries of every class at the reset mtu of 1500
  task automatic test_corner_frames();
    in_item_t f;
    send_idle = 0;
    recv_stall = 0;
    send_frame(frame_of(FC_NO_DS, 0, rand48(), rand48()));
    send_frame(frame_of(FC_TO_DS, 27, rand48(), rand48()));
    send_frame(frame_of(FC_FROM_DS, 28, PL_RFC1042, rand48()));
    send_frame(frame_of(FC_WDS, 33, rand48(), rand48()));
    send_frame(frame_of(FC_WDS, 34, PL_RAW, rand48()));
    send_frame(frame_of(FC_NO_DS, 42, PL_RAW, rand48()));
    send_frame(frame_of(FC_TO_DS, 1500 + 14 + 28, PL_RAW, rand48()));
    send_frame(frame_of(FC_TO_DS, 1500 + 15 + 28, PL_RAW, rand48()));
    // payload repeating the addresses is not treated as an ethernet frame
    f = frame_of(FC_NO_DS, 128, '0, '0);
    f.payload_bytes_low = f.address_one;
    f.payload_bytes_high = f.address_two;
    send_frame(f);
    send_frame(frame_of(FC_FROM_DS, 36, PL_VENDOR_SNAP, rand48()));
    send_frame(frame_of(FC_FROM_DS, 1501 + 28, PL_VENDOR_SNAP, rand48()));
    send_frame(frame_of(FC_NO_DS, 36, PL_RFC1042, {ETYPE_IPV4, 32'h4500_0054}));
    send_frame(frame_of(FC_WDS, 1508 + 34, PL_RFC1042, {ETYPE_IPV4, 32'h0}));
    send_frame(frame_of(FC_WDS, 1509 + 34, PL_RFC1042, {ETYPE_IPV4, 32'h0}));
    send_frame(frame_of(FC_TO_DS, 64, PL_RFC1042, {AARP_TYPE, 32'h0001_0800}));
    send_frame(frame_of(FC_NO_DS, 35, PL_RFC1042, rand48()));
    send_frame(frame_of(FC_FROM_DS, 48, PL_BAD_CTRL, rand48()));
    send_frame(frame_of(FC_NO_DS, 48, PL_HALF_SAP, rand48()));
    send_frame(frame_of(FC_TO_DS, 41, PL_RFC1042, {ETYPE_IPX, 32'hFFFF_0000}));
    send_frame(frame_of(FC_NO_DS, 1500 + 28, PL_JUNK_SAP, rand48()));
    send_frame(frame_of(FC_NO_DS, 1501 + 28, PL_JUNK_SAP, rand48()));
    f = frame_of(16'hFFFF, 4095, '1, '1);
    f.address_one = '1;
    f.address_two = '1;
    f.address_three = '1;
    f.address_four = '1;
    send_frame(f);
    f = frame_of(16'h0000, 28, '0, '0);
    f.address_one = '0;
    f.address_two = '0;
    f.address_three = '0;
    f.address_four = '0;
    send_frame(f);
    wait_drained();
  endtask

  // appletalk aarp keeps its snap header only in selective mode
  task automatic test_aarp_selective();
    set_config(1'b1, MTU_RESET);
    send_frame(frame_of(FC_NO_DS, 64, PL_RFC1042, {AARP_TYPE, 32'h0001_0800}));
    send_frame(frame_of(FC_FROM_DS, 64, PL_RFC1042, {ETYPE_IPX, 32'hFFFF_0000}));
    send_frame(frame_of(FC_TO_DS, 64, PL_VENDOR_SNAP, {AARP_TYPE, 32'h0}));
    wait_drained();
  endtask

  task automatic test_mtu_extremes();
    set_config(1'b0, 12'd0);
    run_random_frames(250, 0, 80);
    set_config(1'b1, 12'd4095);
    run_random_frames(300, 28, 28);
  endtask

  task automatic test_random_mix();
    logic [31:0] pick;
    set_config(1'b0, MTU_RESET);
    run_random_frames(300, 0, 0);
    set_config(1'b1, MTU_RESET);
    run_random_frames(300, 80, 0);
    pick = $urandom_range(20, 200);
    set_config(1'b0, pick[11:0]);
    run_random_frames(300, 0, 0);
    pick = $urandom_range(0, 4095);
    set_config(1'b1, pick[11:0]);
    run_random_frames(300, 28, 28);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_frames();
    test_aarp_selective();
    test_mtu_extremes();
    test_random_mix();
    repeat (8) @(posedge clk);
    $display("checked %0d of %0d frames over %0d register settings", results_checked,
             frames_sent, settings_used);
    $display("rejected %0d, raw %0d, snap %0d, dix %0d, other %0d; %0d mismatches",
             rejected_count, class_count[CLS_RAW], class_count[CLS_SNAP],
             class_count[CLS_DIX], class_count[CLS_OTHER], mismatches);
    if (mismatches == 0 && expected_translations.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
